// ===== src/lsf_pkg.sv =====
// Shared types, constants and register codes for the line substring filter.
`default_nettype none
package lsf_pkg;

    localparam int PATTERN_CHARS = 32;
    localparam int LINE_CHARS    = 1023;
    localparam int PAT_W         = $clog2(PATTERN_CHARS + 1);
    localparam int LINE_W        = $clog2(LINE_CHARS + 1);
    localparam int COUNT_W       = 32;
    localparam int BYTE_W        = 8;
    localparam int CFG_IDX_W     = 3;
    localparam int CFG_DATA_W    = 64;
    localparam int FIFO_DEPTH    = 4;
    localparam int FIFO_PTR_W    = $clog2(FIFO_DEPTH);
    localparam int FIFO_CNT_W    = $clog2(FIFO_DEPTH + 1);

    localparam logic [BYTE_W-1:0]  NEWLINE   = 8'd10;
    localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

    localparam logic KIND_VERDICT = 1'b0;
    localparam logic KIND_COUNT   = 1'b1;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_INVERT    = 3'd0,
        CFG_PAT_LEN   = 3'd1,
        CFG_PAT_0_7   = 3'd2,
        CFG_PAT_8_15  = 3'd3,
        CFG_PAT_16_23 = 3'd4,
        CFG_PAT_24_31 = 3'd5
    } t_cfg_index;

    typedef struct packed {
        logic [BYTE_W-1:0] text_byte;
        logic              end_of_input;
    } t_in_word;

    typedef struct packed {
        logic               result_kind;
        logic               line_selected;
        logic [COUNT_W-1:0] line_number;
        logic [COUNT_W-1:0] selected_count;
        logic               last_result;
    } t_out_word;

    typedef struct packed {
        logic      push_a;
        logic      push_b;
        t_out_word word_a;
        t_out_word word_b;
    } t_fifo_push;

endpackage
`default_nettype wire

// ===== src/lsf_out_fifo.sv =====
// Result queue: takes up to two words a cycle, hands out one.
`default_nettype none
module lsf_out_fifo
    import lsf_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire t_fifo_push i_push,
    output logic            o_room2,
    output logic            o_out_valid,
    input  wire logic       i_out_ready,
    output t_out_word       o_out_data
);

    t_out_word                r_mem [FIFO_DEPTH];
    logic [FIFO_PTR_W-1:0]    r_wr_ptr;
    logic [FIFO_PTR_W-1:0]    r_rd_ptr;
    logic [FIFO_CNT_W-1:0]    r_count;
    logic [FIFO_PTR_W-1:0]    n_wr_ptr;
    logic [FIFO_PTR_W-1:0]    n_rd_ptr;
    logic [FIFO_CNT_W-1:0]    n_count;
    logic [FIFO_PTR_W-1:0]    w_wr_next;
    logic                     w_pop;
    logic [1:0]               w_pushes;

    assign w_pop     = o_out_valid & i_out_ready;
    assign w_wr_next = r_wr_ptr + FIFO_PTR_W'(1);
    assign w_pushes  = {1'b0, i_push.push_a} + {1'b0, i_push.push_b};

    assign o_out_valid = (r_count != '0);
    assign o_out_data  = r_mem[r_rd_ptr];
    assign o_room2     = (r_count <= FIFO_CNT_W'(FIFO_DEPTH - 2));

    always_comb begin
        n_wr_ptr = r_wr_ptr + FIFO_PTR_W'(w_pushes);
        n_rd_ptr = w_pop ? r_rd_ptr + FIFO_PTR_W'(1) : r_rd_ptr;
        n_count  = r_count + FIFO_CNT_W'(w_pushes) - FIFO_CNT_W'(w_pop);
    end

    always_ff @(posedge i_clk) begin
        if (i_push.push_a) begin
            r_mem[r_wr_ptr] <= i_push.word_a;
        end
        if (i_push.push_b) begin
            r_mem[w_wr_next] <= i_push.word_b;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

endmodule
`default_nettype wire

// ===== src/line_substring_filter.sv =====
// Top level of the line substring filter: window compare, line state and result queue.
//
// Scans a text stream one byte per cycle and reports, for each line, its number and
// whether it contains the configured pattern (inverted when r_invert is set). A line
// ends after a newline, after LINE_CHARS bytes, or at end of input; end of input also
// reports the selected-line count and restarts line numbering. The last 32 bytes sit in
// a shift window that is compared against all pattern bytes at once, and results go
// through a four-word queue. An end-of-input word can give two results, so the queue
// takes a new input word only while two entries are free; with the output side always
// ready the sustained rate is one word per cycle. The user must write configuration
// registers through the plain write port while the block idles; this is not enforced.
`default_nettype none
module line_substring_filter
    import lsf_pkg::*;
(
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_wdata,
    input  wire logic                  i_in_valid,
    output logic                       o_in_ready,
    input  wire t_in_word              i_in_data,
    output logic                       o_out_valid,
    input  wire logic                  i_out_ready,
    output t_out_word                  o_out_data
);

    logic                             r_invert;
    logic [PAT_W-1:0]                 r_pat_len;
    logic [PATTERN_CHARS*BYTE_W-1:0]  r_pattern;

    logic [BYTE_W-1:0]  r_window [PATTERN_CHARS];
    logic [PAT_W-1:0]   r_win_cnt;
    logic [LINE_W-1:0]  r_line_cnt;
    logic               r_matched;
    logic [COUNT_W-1:0] r_current_line;
    logic [COUNT_W-1:0] r_sel_total;

    logic [PAT_W-1:0]   n_win_cnt;
    logic [LINE_W-1:0]  n_line_cnt;
    logic               n_matched;
    logic [COUNT_W-1:0] n_current_line;
    logic [COUNT_W-1:0] n_sel_total;

    logic                            w_acc;
    logic                            w_eoi;
    logic [BYTE_W-1:0]               w_byte;
    logic [BYTE_W-1:0]               w_shifted [PATTERN_CHARS];
    logic [PATTERN_CHARS*BYTE_W-1:0] w_rev;
    logic [PATTERN_CHARS*BYTE_W-1:0] w_aligned;
    logic [PAT_W-1:0]                w_len;
    logic [PAT_W-1:0]                w_shift;
    logic [PATTERN_CHARS-1:0]        w_eq;
    logic                            w_hit;
    logic [PAT_W-1:0]                w_win_inc;
    logic [LINE_W-1:0]               w_line_inc;
    logic                            w_line_end;
    logic                            w_vmatch;
    logic                            w_sel;
    logic [COUNT_W-1:0]              w_sel_total_v;
    logic [COUNT_W-1:0]              w_line_next;
    t_out_word                       w_verdict;
    t_out_word                       w_count_word;
    t_fifo_push                      w_push;
    logic                            w_room2;

    assign w_acc  = i_in_valid & o_in_ready;
    assign w_eoi  = i_in_data.end_of_input;
    assign w_byte = i_in_data.text_byte;
    assign o_in_ready = w_room2;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_invert  <= 1'b0;
            r_pat_len <= '0;
            r_pattern <= '0;
        end else if (i_cfg_we) begin
            case (t_cfg_index'(i_cfg_index))
                CFG_INVERT:    r_invert  <= i_cfg_wdata[0];
                CFG_PAT_LEN:   r_pat_len <= i_cfg_wdata[PAT_W-1:0];
                CFG_PAT_0_7:   r_pattern[0*CFG_DATA_W +: CFG_DATA_W] <= i_cfg_wdata;
                CFG_PAT_8_15:  r_pattern[1*CFG_DATA_W +: CFG_DATA_W] <= i_cfg_wdata;
                CFG_PAT_16_23: r_pattern[2*CFG_DATA_W +: CFG_DATA_W] <= i_cfg_wdata;
                CFG_PAT_24_31: r_pattern[3*CFG_DATA_W +: CFG_DATA_W] <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    // window compare: align the newest bytes with the pattern, compare all at once
    always_comb begin
        w_shifted[0] = w_byte;
        for (int k = 1; k < PATTERN_CHARS; k++) begin
            w_shifted[k] = r_window[k-1];
        end
        for (int j = 0; j < PATTERN_CHARS; j++) begin
            w_rev[j*BYTE_W +: BYTE_W] = w_shifted[PATTERN_CHARS-1-j];
        end
        w_len   = (r_pat_len > PAT_W'(PATTERN_CHARS)) ? PAT_W'(PATTERN_CHARS) : r_pat_len;
        w_shift = PAT_W'(PATTERN_CHARS) - w_len;
        w_aligned = w_rev >> {w_shift, 3'b000};
        for (int j = 0; j < PATTERN_CHARS; j++) begin
            w_eq[j] = (w_aligned[j*BYTE_W +: BYTE_W] == r_pattern[j*BYTE_W +: BYTE_W])
                      || (PAT_W'(j) >= w_len);
        end
        w_win_inc  = (r_win_cnt == PAT_W'(PATTERN_CHARS)) ? r_win_cnt
                                                          : r_win_cnt + PAT_W'(1);
        w_line_inc = (r_line_cnt == LINE_W'(LINE_CHARS)) ? r_line_cnt
                                                         : r_line_cnt + LINE_W'(1);
        w_hit      = (w_len != '0) && (w_win_inc >= w_len) && (&w_eq);
        w_line_end = (w_byte == NEWLINE) || (w_line_inc >= LINE_W'(LINE_CHARS));
    end

    // verdict and count words
    always_comb begin
        w_vmatch = (w_len == '0) || r_matched || (!w_eoi && w_hit);
        w_sel    = w_vmatch ^ r_invert;
        w_sel_total_v = (w_sel && (r_sel_total != COUNT_MAX)) ? r_sel_total + COUNT_W'(1)
                                                              : r_sel_total;
        w_line_next = (r_current_line != COUNT_MAX) ? r_current_line + COUNT_W'(1)
                                                    : r_current_line;

        w_verdict.result_kind    = KIND_VERDICT;
        w_verdict.line_selected  = w_sel;
        w_verdict.line_number    = r_current_line;
        w_verdict.selected_count = w_sel_total_v;
        w_verdict.last_result    = !w_eoi;

        w_count_word.result_kind    = KIND_COUNT;
        w_count_word.line_selected  = 1'b0;
        w_count_word.line_number    = '0;
        w_count_word.selected_count = (r_line_cnt != '0) ? w_sel_total_v : r_sel_total;
        w_count_word.last_result    = 1'b1;

        w_push.push_a = 1'b0;
        w_push.push_b = 1'b0;
        w_push.word_a = w_verdict;
        w_push.word_b = w_count_word;
        if (w_acc) begin
            if (w_eoi) begin
                w_push.push_a = 1'b1;
                if (r_line_cnt != '0) begin
                    w_push.push_b = 1'b1;
                end else begin
                    w_push.word_a = w_count_word;
                end
            end else begin
                w_push.push_a = w_line_end;
            end
        end
    end

    // line and stream state
    always_comb begin
        n_win_cnt      = r_win_cnt;
        n_line_cnt     = r_line_cnt;
        n_matched      = r_matched;
        n_current_line = r_current_line;
        n_sel_total    = r_sel_total;
        if (w_acc) begin
            if (w_eoi) begin
                n_win_cnt      = '0;
                n_line_cnt     = '0;
                n_matched      = 1'b0;
                n_current_line = COUNT_W'(1);
                n_sel_total    = '0;
            end else if (w_line_end) begin
                n_win_cnt      = '0;
                n_line_cnt     = '0;
                n_matched      = 1'b0;
                n_current_line = w_line_next;
                n_sel_total    = w_sel_total_v;
            end else begin
                n_win_cnt  = w_win_inc;
                n_line_cnt = w_line_inc;
                n_matched  = r_matched | w_hit;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_acc && !w_eoi) begin
            for (int k = 0; k < PATTERN_CHARS; k++) begin
                r_window[k] <= w_shifted[k];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_win_cnt      <= '0;
            r_line_cnt     <= '0;
            r_matched      <= 1'b0;
            r_current_line <= COUNT_W'(1);
            r_sel_total    <= '0;
        end else begin
            r_win_cnt      <= n_win_cnt;
            r_line_cnt     <= n_line_cnt;
            r_matched      <= n_matched;
            r_current_line <= n_current_line;
            r_sel_total    <= n_sel_total;
        end
    end

    lsf_out_fifo u_out_fifo (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (w_push),
        .o_room2     (w_room2),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

    a_eoi_restarts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_acc && w_eoi |=> r_current_line == COUNT_W'(1) && r_line_cnt == '0
                           && r_sel_total == '0)
        else $error("stream state not restarted after end of input");

    a_eoi_gives_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_acc && w_eoi |=> o_out_valid)
        else $error("end of input gave no result");

    a_line_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_line_cnt < LINE_W'(LINE_CHARS) && r_win_cnt <= PAT_W'(PATTERN_CHARS))
        else $error("line or window count out of range");

    a_newline_gives_verdict: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_acc && !w_eoi && w_byte == NEWLINE |=> o_out_valid && r_line_cnt == '0)
        else $error("newline did not close the line");

endmodule
`default_nettype wire
